// ----- rtl/core/servo_command_line_parser_assert.svh -----
// Assertion macros used by the servo command line parser port checker, svclp_checker.
// Needs a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef SERVO_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERVO_COMMAND_LINE_PARSER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SCLP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("servo command line parser check failed");

// Property checked at every clock edge, reset included.
`define SCLP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("servo command line parser reset check failed");

`endif

// ----- rtl/core/svclp_pkg.sv -----
// Shared types, character codes and helper functions of the servo command line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package svclp_pkg;

    // Default number of line buffer slots.
    localparam int LINE_SLOTS_DEF = 5;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEL_A = 8'h41;
    localparam logic [7:0] CH_SEL_D = 8'h44;

    // Result of the line parser for the byte under work.
    typedef struct packed {
        logic       hit;    // byte is a newline that completes a valid command
        logic [1:0] sel;    // servo index, 0 = A
        logic [7:0] angle;  // converted angle, modulo 256
    } t_line_res;

    // Whitespace as skipped before the sign.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                   (c == CH_FF) || (c == CH_NL) || (c == CH_CR);
    endfunction

    // Decimal digit test.
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- rtl/core/servo_command_line_parser.sv -----
// Channel   | Dir | Payload (tdata, low bit first)
// s_axis    | in  | rx_byte[7:0]
// m_axis    | out | servo_select[1:0], angle[9:2], zero pad[15:10]
//
// Every received byte is held in the input register while the line
// parser works on it; a completed command then goes into the output register.
// One byte is taken per cycle; only a newline that completes a valid command
// and meets the single output register full and stalled holds the input side.
// Synchronous active-low reset clears the line position and both valid flags.
// Depends on svclp_pkg and svclp_line_parser.
`timescale 1ns / 1ps

module servo_command_line_parser
    import svclp_pkg::*;
#(
    parameter int LINE_SLOTS = LINE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] servo_select, [9:2] angle, [15:10] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [1:0] r_out_sel;
    logic [7:0] r_out_angle;

    t_line_res res;
    logic      advance;

    // Line state and number conversion.
    svclp_line_parser #(
        .LINE_SLOTS (LINE_SLOTS)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // The held byte moves on unless it carries a result into a stalled output.
    assign advance       = r_in_valid && (!res.hit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.hit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && res.hit) begin
            r_out_sel   <= res.sel;
            r_out_angle <= res.angle;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_angle, r_out_sel};

endmodule

// ----- rtl/core/svclp_line_parser.sv -----
// Line state of the servo command parser: write position, selector byte and a
// running number conversion updated one byte at a time. Depends on svclp_pkg.
`timescale 1ns / 1ps

module svclp_line_parser
    import svclp_pkg::*;
#(
    parameter int LINE_SLOTS = LINE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,      // consume i_byte this cycle
    input  logic [7:0] i_byte,
    output t_line_res  o_res        // outcome of i_byte against the current line
);

    localparam int WP_W = $clog2(LINE_SLOTS);

    // Phase of the number conversion over slots 1 and up.
    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGITS,
        PH_DONE
    } t_num_phase;

    logic [WP_W-1:0] r_wp, n_wp;
    logic [7:0]      r_sel, n_sel;
    t_num_phase      r_phase, n_phase;
    logic            r_neg, n_neg;
    logic [7:0]      r_acc, n_acc;

    logic [7:0] digit_val;
    logic [7:0] acc_x10;
    logic       sel_ok;

    assign digit_val = i_byte - CH_ZERO;
    assign acc_x10   = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0};
    assign sel_ok    = (r_sel >= CH_SEL_A) && (r_sel <= CH_SEL_D);

    // A newline closes a non-empty line; the selector must name a servo.
    always_comb begin
        o_res.hit   = (i_byte == CH_NL) && (r_wp != '0) && sel_ok;
        o_res.sel   = 2'(r_sel - CH_SEL_A);
        o_res.angle = r_neg ? 8'(8'd0 - r_acc) : r_acc;
    end

    // Next line state for the byte under work.
    always_comb begin
        n_wp    = r_wp;
        n_sel   = r_sel;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (i_byte == CH_CR) begin
            // Carriage returns leave the line untouched.
        end else if (i_byte == CH_NL) begin
            n_wp = '0;
        end else begin
            // Advance the write position with wrap at the last slot.
            if (r_wp == WP_W'(LINE_SLOTS - 1)) begin
                n_wp = '0;
            end else begin
                n_wp = r_wp + 1'b1;
            end
            if (r_wp == '0) begin
                // Slot 0 starts a fresh line and holds the selector.
                n_sel   = i_byte;
                n_phase = PH_BLANK;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                case (r_phase)
                    PH_BLANK: begin
                        if (is_blank(i_byte)) begin
                            n_phase = PH_BLANK;
                        end else if (i_byte == CH_PLUS || i_byte == CH_MINUS) begin
                            n_neg   = (i_byte == CH_MINUS);
                            n_phase = PH_DIGITS;
                        end else if (is_digit(i_byte)) begin
                            n_acc   = digit_val;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit(i_byte)) begin
                            n_acc = acc_x10 + digit_val;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Line state registers; the selector and number payload need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_phase <= PH_BLANK;
        end else if (i_step) begin
            r_wp    <= n_wp;
            r_phase <= n_phase;
        end
        if (i_step) begin
            r_sel <= n_sel;
            r_neg <= n_neg;
            r_acc <= n_acc;
        end
    end

endmodule

// ----- rtl/core/svclp_checker.sv -----
// Port-level checks on the servo command line parser, bound to the top level.
// Depends on svclp_pkg and the macros in servo_command_line_parser_assert.svh.
`timescale 1ns / 1ps
`include "servo_command_line_parser_assert.svh"

module svclp_checker
    import svclp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic nl_transfer;

    assign nl_transfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_NL);

    // Reset empties the output register.
    `SCLP_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid)

    // A stalled result stays put.
    `SCLP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // The pad bits above the angle are zero.
    `SCLP_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b000000)

    // A result appearing on an idle output comes from a newline transfer that passed through the input register.
    `SCLP_ASSERT(a_result_from_nl, $rose(m_axis_tvalid) |-> $past(nl_transfer, 2))

endmodule

bind servo_command_line_parser svclp_checker u_svclp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/servo_command_line_parser_checker.sv -----
// Checker for the servo command line parser: watches both stream channels,
// predicts each servo command from the accepted bytes and compares results.
// Depends on svclp_pkg for the character codes and the default line size.
`timescale 1ns / 1ps

module servo_command_line_parser_checker
    import svclp_pkg::*;
#(
    parameter int LINE_SLOTS = LINE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,      // [7:0] rx_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,     // [1:0] servo_select, [9:2] angle, [15:10] zero
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] servo;
        logic [7:0] angle;
    } servo_cmd_t;

    // Shadow copy of the line buffer and its write position.
    logic [7:0] line_buf [LINE_SLOTS];
    int         wr_pos;
    servo_cmd_t expected_cmds [$];
    int         fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
        wr_pos       = 0;
    end

    // Converts slots 1 up to stop the way atoi does, keeping the low 8 bits.
    function automatic logic [7:0] convert_angle(input int stop);
        logic [7:0] acc;
        logic       neg;
        int         k;
        acc = 8'd0;
        neg = 1'b0;
        k   = 1;
        while (k < stop && (line_buf[k] == CH_SPACE || line_buf[k] == CH_TAB ||
                            line_buf[k] == CH_VT || line_buf[k] == CH_FF ||
                            line_buf[k] == CH_NL || line_buf[k] == CH_CR))
            k++;
        if (k < stop && (line_buf[k] == CH_PLUS || line_buf[k] == CH_MINUS)) begin
            neg = (line_buf[k] == CH_MINUS);
            k++;
        end
        while (k < stop && line_buf[k] >= CH_ZERO && line_buf[k] <= CH_NINE) begin
            acc = acc * 8'd10 + (line_buf[k] - CH_ZERO);
            k++;
        end
        if (neg)
            acc = -acc;
        return acc;
    endfunction

    // Applies one accepted byte to the shadow line and queues any command it completes.
    task automatic predict_command(input logic [7:0] c);
        servo_cmd_t cmd;
        if (c == CH_NL) begin
            // A line that wrapped back to slot 0 or has no valid selector gives nothing.
            if (wr_pos != 0 && line_buf[0] >= CH_SEL_A && line_buf[0] <= CH_SEL_D) begin
                cmd.servo = 2'(line_buf[0] - CH_SEL_A);
                cmd.angle = convert_angle(wr_pos);
                expected_cmds.push_back(cmd);
            end
            wr_pos = 0;
        end else if (c != CH_CR) begin
            line_buf[wr_pos] = c;
            wr_pos = (wr_pos == LINE_SLOTS - 1) ? 0 : wr_pos + 1;
        end
    endtask

    // Results are checked before the same edge's input is applied, since the
    // block cannot answer a byte in the cycle it is accepted.
    always @(posedge i_clk) begin : monitor
        servo_cmd_t want;
        if (!i_rst_n) begin
            wr_pos = 0;
            expected_cmds.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected result transfer, tdata = 0x%04h", i_out_data);
                    fails++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_out_data[1:0] !== want.servo) begin
                        $error("servo_select: expected %0d, actual %0d",
                               want.servo, i_out_data[1:0]);
                        fails++;
                    end
                    if (i_out_data[9:2] !== want.angle) begin
                        $error("angle: expected %0d, actual %0d",
                               want.angle, i_out_data[9:2]);
                        fails++;
                    end
                    if (i_out_data[15:10] !== 6'd0) begin
                        $error("pad: expected 0, actual 0x%02h", i_out_data[15:10]);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_command(i_in_data);
        end
        o_pending    <= expected_cmds.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/tb_servo_command_line_parser.sv -----
// Top of the servo command line parser testbench: clock, reset, byte stimulus,
// random result back-pressure and the final verdict.
// Depends on svclp_pkg, the parser RTL and servo_command_line_parser_checker.
`timescale 1ns / 1ps

module tb_servo_command_line_parser;
    import svclp_pkg::*;

    localparam int RUN_ITEMS   = 825;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_GAP     = 17;

    // Hand-picked lines: empty, selector only, negative, blank with plus and a
    // carriage return, a wrapped buffer with extreme bytes, an unknown selector.
    localparam logic [7:0] DIRECTED_TEXT [25] = '{
        CH_NL,
        CH_SEL_A, CH_NL,
        "B", CH_MINUS, "9", "9", CH_NL,
        "C", CH_TAB, CH_PLUS, "7", CH_CR, CH_NL,
        8'h00, 8'hFF, "3", "4", "5", CH_SEL_D, "9", CH_NL,
        "E", "1", CH_NL
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [1:0] servo_select, [9:2] angle, [15:10] zero

    int   fail_count;
    int   pending_cmds;
    int   items_sent   = 0;
    int   cycle_count  = 0;
    logic quiet_phase  = 1'b0;
    logic hold_request = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    servo_command_line_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    servo_command_line_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_cmds)
    );

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one byte after a random gap and returns at the edge of its transfer.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (c != CH_CR)
            items_sent++;
    endtask

    // Waits until every predicted command has arrived, then lets the pipeline settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_cmds != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Mostly well-formed command lines with random content; the rest is noise,
    // overlong lines and lines without a newline.
    task automatic send_random_line();
        logic [7:0] blank_chars [4];
        logic [7:0] text [$];
        blank_chars = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 99) < 88)
                text.push_back(CH_SEL_A + 8'($urandom_range(0, 3)));
            else
                text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 20)
                text.push_back(blank_chars[$urandom_range(0, 3)]);
            if ($urandom_range(0, 99) < 30)
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            repeat ($urandom_range(0, 3)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 99) < 10)
                text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 8)
                repeat ($urandom_range(1, 6))
                    text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 99) < 6)
                text.insert($urandom_range(0, text.size()), CH_CR);
            if ($urandom_range(0, 99) < 95)
                text.push_back(CH_NL);
        end
        foreach (text[k])
            send_byte(text[k]);
    endtask

    // Result side: a random stall before each transfer, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
        end
    end

    // Stimulus and verdict.
    initial begin : byte_source
        logic hold_done;
        logic drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_TEXT[k])
            send_byte(DIRECTED_TEXT[k]);

        while (items_sent < RUN_ITEMS) begin
            quiet_phase = (items_sent >= 100 && items_sent < 160) ||
                          (items_sent >= 600 && items_sent < 660);
            if (!hold_done && items_sent >= 250) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && items_sent >= 450) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
            send_random_line();
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
